// File: rtl/tinted_alpha_over_blend_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tinted alpha-over blend.
// Each macro expects clk_i and rst_ni in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef TINTED_ALPHA_OVER_BLEND_ASSERT_SVH
`define TINTED_ALPHA_OVER_BLEND_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAOB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TAOB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/taob_pkg.sv
// ----------------------------------------------------------------------------
// taob_pkg
// Types, widths and helpers shared by the tinted alpha-over blend.
// ----------------------------------------------------------------------------
package taob_pkg;

  localparam int ChW      = 8;   // color channel width
  localparam int TintW    = 9;   // Q1.8 tint width
  localparam int TintFrac = 8;   // fraction bits of the tint
  localparam int DenW     = 16;  // width of a*255 + da*(255-a)
  localparam int NumerW   = 24;  // width of the per-channel dividend
  localparam int Lanes    = 3;   // red, green, blue go through the divider
  localparam int DivSteps = 2;   // quotient bits resolved per divider stage
  localparam int DivStages = ChW / DivSteps;
  localparam int AddrW    = 4;
  localparam int RegIdxW  = 2;
  localparam int DataW    = 32;

  localparam logic [ChW-1:0]   ChMax     = 8'd255;
  localparam logic [TintW-1:0] TintReset = 9'd256;

  localparam logic [RegIdxW-1:0] RegTintRed   = 2'd0;
  localparam logic [RegIdxW-1:0] RegTintGreen = 2'd1;
  localparam logic [RegIdxW-1:0] RegTintBlue  = 2'd2;
  localparam logic [RegIdxW-1:0] RegTintAlpha = 2'd3;

  typedef struct packed {
    logic [ChW-1:0] red;
    logic [ChW-1:0] green;
    logic [ChW-1:0] blue;
    logic [ChW-1:0] alpha;
  } pix_t;

  typedef logic [Lanes-1:0][NumerW-1:0] numer_vec_t;
  typedef logic [Lanes-1:0][ChW-1:0]    quot_vec_t;

  // Scale a channel by a Q1.8 tint, truncate, and saturate to full scale.
  function automatic logic [ChW-1:0] tint_apply(input logic [ChW-1:0] chan,
                                                input logic [TintW-1:0] tint);
    logic [ChW+TintW-1:0] prod;
    logic [ChW-1:0]       res;
    prod = (ChW+TintW)'(chan) * (ChW+TintW)'(tint);
    if (prod[ChW+TintW-1:TintFrac+ChW] != '0) begin
      res = ChMax;
    end else begin
      res = prod[TintFrac+ChW-1:TintFrac];
    end
    return res;
  endfunction

endpackage

// File: rtl/taob_div.sv
// ----------------------------------------------------------------------------
// taob_div
// Pipelined restoring divider for the three color lanes. All lanes share one
// divisor; the quotient is known to fit in one channel, and each stage
// resolves a fixed number of quotient bits, most significant first.
// ----------------------------------------------------------------------------
module taob_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  taob_pkg::numer_vec_t           numer_i,
  input  logic [taob_pkg::DenW-1:0]      den_i,
  output logic                           valid_o,
  output taob_pkg::quot_vec_t            quot_o
);

  localparam int NStg = taob_pkg::DivStages;

  logic [NStg-1:0]                         valid_q;
  taob_pkg::numer_vec_t [NStg-1:0]         rem_q;
  logic [NStg-1:0][taob_pkg::DenW-1:0]     den_q;
  taob_pkg::quot_vec_t [NStg-1:0]          quo_q;

  for (genvar s = 0; s < NStg; s++) begin : g_stage
    localparam int TopBit = taob_pkg::ChW - 1 - s * taob_pkg::DivSteps;

    logic                        v_in;
    taob_pkg::numer_vec_t        rem_in;
    logic [taob_pkg::DenW-1:0]   den_in;
    taob_pkg::quot_vec_t         quo_in;
    taob_pkg::numer_vec_t        rem_d;
    taob_pkg::quot_vec_t         quo_d;

    if (s == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = numer_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = valid_q[s-1];
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    for (genvar l = 0; l < taob_pkg::Lanes; l++) begin : g_lane
      always_comb begin
        logic [taob_pkg::NumerW-1:0] rem;
        logic [taob_pkg::ChW-1:0]    quo;
        logic [taob_pkg::NumerW-1:0] shifted;
        logic [taob_pkg::NumerW:0]   trial;
        rem = rem_in[l];
        quo = quo_in[l];
        for (int k = 0; k < taob_pkg::DivSteps; k++) begin
          shifted = taob_pkg::NumerW'(den_in) << (TopBit - k);
          trial   = {1'b0, rem} - {1'b0, shifted};
          if (!trial[taob_pkg::NumerW]) begin
            rem = trial[taob_pkg::NumerW-1:0];
            quo = quo | (taob_pkg::ChW'(1) << (TopBit - k));
          end
        end
        rem_d[l] = rem;
        quo_d[l] = quo;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[s] <= rem_d;
      den_q[s] <= den_in;
      quo_q[s] <= quo_d;
    end
  end

  assign valid_o = valid_q[NStg-1];
  assign quot_o  = quo_q[NStg-1];

endmodule

// File: rtl/tinted_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// tinted_alpha_over_blend
// Tints a source RGBA8 pixel by four Q1.8 registers and composites it over
// the destination pixel with straight alpha, one pixel per clock.
//
//  channel  direction  handshake                         payload
//  -------  ---------  --------------------------------  -----------------------
//  pixel    in         start && !busy                    src_*_i, dst_*_i
//  result   out        out_valid_o, one cycle, no stall  out_*_o
//  config   in/out     psel && penable && pwrite (APB)   paddr, pwdata, prdata
//
// A pixel may be accepted on every clock; busy is never raised.
// From accept to the result edge a pixel passes the tint stage, two product
// stages, a four-stage divider (two quotient bits per stage) and the result
// register. Reset sets every tint to 1.0 and clears all pipeline valid bits.
// The receiver cannot stall, so the pipeline advances on every clock.
// ----------------------------------------------------------------------------
`include "tinted_alpha_over_blend_assert.svh"

module tinted_alpha_over_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel input
  input  logic                            start,
  output logic                            busy,
  input  logic [taob_pkg::ChW-1:0]        src_red_i,
  input  logic [taob_pkg::ChW-1:0]        src_green_i,
  input  logic [taob_pkg::ChW-1:0]        src_blue_i,
  input  logic [taob_pkg::ChW-1:0]        src_alpha_i,
  input  logic [taob_pkg::ChW-1:0]        dst_red_i,
  input  logic [taob_pkg::ChW-1:0]        dst_green_i,
  input  logic [taob_pkg::ChW-1:0]        dst_blue_i,
  input  logic [taob_pkg::ChW-1:0]        dst_alpha_i,
  // result output
  output logic                            out_valid_o,
  output logic [taob_pkg::ChW-1:0]        out_red_o,
  output logic [taob_pkg::ChW-1:0]        out_green_o,
  output logic [taob_pkg::ChW-1:0]        out_blue_o,
  output logic [taob_pkg::ChW-1:0]        out_alpha_o,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [taob_pkg::AddrW-1:0]      paddr,
  input  logic [taob_pkg::DataW-1:0]      pwdata,
  output logic [taob_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  localparam int ChW     = taob_pkg::ChW;
  localparam int TintW   = taob_pkg::TintW;
  localparam int DenW    = taob_pkg::DenW;
  localparam int NumerW  = taob_pkg::NumerW;
  localparam int NStg    = taob_pkg::DivStages;
  localparam int Latency = 3 + NStg + 1;

  typedef struct packed {
    logic          bypass;
    taob_pkg::pix_t dst;
    logic [ChW-1:0] alpha;
  } side_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [TintW-1:0] tint_red_q, tint_green_q, tint_blue_q, tint_alpha_q;
  logic [taob_pkg::RegIdxW-1:0] reg_idx;
  logic cfg_we;

  assign pready  = 1'b1;
  assign reg_idx = paddr[taob_pkg::AddrW-1:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tint_red_q   <= taob_pkg::TintReset;
      tint_green_q <= taob_pkg::TintReset;
      tint_blue_q  <= taob_pkg::TintReset;
      tint_alpha_q <= taob_pkg::TintReset;
    end else if (cfg_we) begin
      unique case (reg_idx)
        taob_pkg::RegTintRed:   tint_red_q   <= pwdata[TintW-1:0];
        taob_pkg::RegTintGreen: tint_green_q <= pwdata[TintW-1:0];
        taob_pkg::RegTintBlue:  tint_blue_q  <= pwdata[TintW-1:0];
        taob_pkg::RegTintAlpha: tint_alpha_q <= pwdata[TintW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      taob_pkg::RegTintRed:   prdata = {{(taob_pkg::DataW-TintW){1'b0}}, tint_red_q};
      taob_pkg::RegTintGreen: prdata = {{(taob_pkg::DataW-TintW){1'b0}}, tint_green_q};
      taob_pkg::RegTintBlue:  prdata = {{(taob_pkg::DataW-TintW){1'b0}}, tint_blue_q};
      taob_pkg::RegTintAlpha: prdata = {{(taob_pkg::DataW-TintW){1'b0}}, tint_alpha_q};
      default:                prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Stage 1: tint the source, register both pixels
  // --------------------------------------------------------------------------
  logic           accept;
  logic           v1_q;
  taob_pkg::pix_t src1_q, dst1_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i) begin
    src1_q.red   <= taob_pkg::tint_apply(src_red_i,   tint_red_q);
    src1_q.green <= taob_pkg::tint_apply(src_green_i, tint_green_q);
    src1_q.blue  <= taob_pkg::tint_apply(src_blue_i,  tint_blue_q);
    src1_q.alpha <= taob_pkg::tint_apply(src_alpha_i, tint_alpha_q);
    dst1_q       <= {dst_red_i, dst_green_i, dst_blue_i, dst_alpha_i};
  end

  // --------------------------------------------------------------------------
  // Stage 2: first products, c*a and d*da per lane, plus the alpha terms
  // --------------------------------------------------------------------------
  logic                              v2_q;
  logic [taob_pkg::Lanes-1:0][DenW-1:0] pa2_q, pd2_q;
  logic [DenW-1:0]                   a255_2_q, dainv2_q;
  logic [ChW-1:0]                    inv2_q;
  taob_pkg::pix_t                    dst2_q;
  logic                              bypass2_q;
  logic [ChW-1:0]                    inv1;
  logic [taob_pkg::Lanes-1:0][ChW-1:0] s1_lane, d1_lane;

  assign inv1    = taob_pkg::ChMax - src1_q.alpha;
  assign s1_lane = {src1_q.red, src1_q.green, src1_q.blue};
  assign d1_lane = {dst1_q.red, dst1_q.green, dst1_q.blue};

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < taob_pkg::Lanes; l++) begin
      pa2_q[l] <= DenW'(s1_lane[l]) * DenW'(src1_q.alpha);
      pd2_q[l] <= DenW'(d1_lane[l]) * DenW'(dst1_q.alpha);
    end
    a255_2_q  <= (DenW'(src1_q.alpha) << ChW) - DenW'(src1_q.alpha);
    dainv2_q  <= DenW'(dst1_q.alpha) * DenW'(inv1);
    inv2_q    <= inv1;
    dst2_q    <= dst1_q;
    bypass2_q <= (src1_q.alpha == '0);
  end

  // --------------------------------------------------------------------------
  // Stage 3: dividends c*a*255 + d*da*(255-a) and the divisor
  // --------------------------------------------------------------------------
  logic                 v3_q;
  taob_pkg::numer_vec_t numer3_q;
  logic [DenW-1:0]      den3_q;
  taob_pkg::pix_t       dst3_q;
  logic                 bypass3_q;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < taob_pkg::Lanes; l++) begin
      numer3_q[l] <= ((NumerW'(pa2_q[l]) << ChW) - NumerW'(pa2_q[l]))
                     + NumerW'(pd2_q[l]) * NumerW'(inv2_q);
    end
    // The sum never exceeds 255*255, so it fits the divisor width.
    den3_q    <= DenW'(a255_2_q + dainv2_q);
    dst3_q    <= dst2_q;
    bypass3_q <= bypass2_q;
  end

  // --------------------------------------------------------------------------
  // Divider and the side data that runs beside it
  // --------------------------------------------------------------------------
  logic                div_valid;
  taob_pkg::quot_vec_t div_quot;
  side_t [NStg-1:0]    side_q;
  logic [DenW+ChW+1:0] alpha_prod;

  taob_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .numer_i (numer3_q),
    .den_i   (den3_q),
    .valid_o (div_valid),
    .quot_o  (div_quot)
  );

  // Divide by 255 as (n+1)*257 >> 16, exact for every divisor value here.
  assign alpha_prod = ((DenW+ChW+2)'(den3_q) + 1'b1) * (DenW+ChW+2)'(257);

  always_ff @(posedge clk_i) begin
    side_q[0].bypass <= bypass3_q;
    side_q[0].dst    <= dst3_q;
    side_q[0].alpha  <= alpha_prod[DenW+ChW-1:DenW];
    for (int i = 1; i < NStg; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  logic           out_valid_q;
  taob_pkg::pix_t out_q;

  // Lane 2 carries red and lane 0 carries blue.
  always_ff @(posedge clk_i) begin
    if (side_q[NStg-1].bypass) begin
      out_q <= side_q[NStg-1].dst;
    end else begin
      out_q <= {div_quot[2], div_quot[1], div_quot[0], side_q[NStg-1].alpha};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= div_valid;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q.red;
  assign out_green_o = out_q.green;
  assign out_blue_o  = out_q.blue;
  assign out_alpha_o = out_q.alpha;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `TAOB_ASSERT_IMP(a_result_follows_accept, accept, ##Latency out_valid_o, "result beat missing after accept")
  `TAOB_ASSERT_IMP(a_result_has_accept, out_valid_o, $past(accept, Latency), "result beat without a matching accept")
  `TAOB_ASSERT_IMP(a_alpha_not_below_dst, out_valid_o, out_alpha_o >= $past(dst_alpha_i, Latency), "blended alpha fell below destination alpha")
  `TAOB_ASSERT_IMP(a_clear_src_bypass, out_valid_o && ($past(src_alpha_i, Latency) == '0), out_red_o == $past(dst_red_i, Latency), "transparent source changed the destination")
  `TAOB_ASSERT_NXT(a_tint_alpha_write, cfg_we && (reg_idx == taob_pkg::RegTintAlpha), tint_alpha_q == $past(pwdata[TintW-1:0]), "alpha tint write lost")

endmodule

// File: verif/tb_tinted_alpha_over_blend.sv
// ----------------------------------------------------------------------------
// tb_tinted_alpha_over_blend
// Self-checking bench for the tinted alpha-over blend. Source and destination
// pixels go in as command beats; a local integer model tints the source and
// composites it over the destination, and every result strobe is compared
// with the oldest predicted pixel. Tint registers are reprogrammed over APB
// between phases once the pipeline has drained.
// ----------------------------------------------------------------------------
module tb_tinted_alpha_over_blend;

  localparam int ResultLatency = 8;
  localparam int WatchdogLimit = 4000;
  localparam int RandomPhases  = 10;
  localparam int PhasePixels   = 115;

  logic                           clk_i   = 1'b0;
  logic                           rst_ni  = 1'b0;
  logic                           start   = 1'b0;
  logic                           busy;
  logic [taob_pkg::ChW-1:0]       src_red_i   = '0;
  logic [taob_pkg::ChW-1:0]       src_green_i = '0;
  logic [taob_pkg::ChW-1:0]       src_blue_i  = '0;
  logic [taob_pkg::ChW-1:0]       src_alpha_i = '0;
  logic [taob_pkg::ChW-1:0]       dst_red_i   = '0;
  logic [taob_pkg::ChW-1:0]       dst_green_i = '0;
  logic [taob_pkg::ChW-1:0]       dst_blue_i  = '0;
  logic [taob_pkg::ChW-1:0]       dst_alpha_i = '0;
  logic                           out_valid_o;
  logic [taob_pkg::ChW-1:0]       out_red_o;
  logic [taob_pkg::ChW-1:0]       out_green_o;
  logic [taob_pkg::ChW-1:0]       out_blue_o;
  logic [taob_pkg::ChW-1:0]       out_alpha_o;
  logic                           psel    = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite  = 1'b0;
  logic [taob_pkg::AddrW-1:0]     paddr   = '0;
  logic [taob_pkg::DataW-1:0]     pwdata  = '0;
  logic [taob_pkg::DataW-1:0]     prdata;
  logic                           pready;

  logic [taob_pkg::TintW-1:0] tint_q [4];
  taob_pkg::pix_t             exp_pixels [$];
  int                         error_count = 0;
  int                         quiet_cycles = 0;

  tinted_alpha_over_blend u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .src_red_i   (src_red_i),
    .src_green_i (src_green_i),
    .src_blue_i  (src_blue_i),
    .src_alpha_i (src_alpha_i),
    .dst_red_i   (dst_red_i),
    .dst_green_i (dst_green_i),
    .dst_blue_i  (dst_blue_i),
    .dst_alpha_i (dst_alpha_i),
    .out_valid_o (out_valid_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o),
    .out_alpha_o (out_alpha_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic taob_pkg::pix_t px(int r, int g, int b, int a);
    taob_pkg::pix_t p;
    p.red   = taob_pkg::ChW'(r);
    p.green = taob_pkg::ChW'(g);
    p.blue  = taob_pkg::ChW'(b);
    p.alpha = taob_pkg::ChW'(a);
    return p;
  endfunction

  // Tint each source channel, then composite over the destination with
  // straight alpha using exact truncating integer division.
  function automatic taob_pkg::pix_t blend_over(taob_pkg::pix_t src, taob_pkg::pix_t dst);
    int unsigned    s_raw [4];
    int unsigned    d_chan [4];
    int unsigned    s_chan [4];
    int unsigned    a, da, inv, den;
    taob_pkg::pix_t res;
    s_raw  = '{src.red, src.green, src.blue, src.alpha};
    d_chan = '{dst.red, dst.green, dst.blue, dst.alpha};
    for (int i = 0; i < 4; i++) begin
      s_chan[i] = (s_raw[i] * tint_q[i]) >> taob_pkg::TintFrac;
      if (s_chan[i] > 255) s_chan[i] = 255;
    end
    a = s_chan[3];
    if (a == 0) return dst;
    da  = d_chan[3];
    inv = 255 - a;
    den = a * 255 + da * inv;
    res.red   = taob_pkg::ChW'((s_chan[0] * a * 255 + d_chan[0] * da * inv) / den);
    res.green = taob_pkg::ChW'((s_chan[1] * a * 255 + d_chan[1] * da * inv) / den);
    res.blue  = taob_pkg::ChW'((s_chan[2] * a * 255 + d_chan[2] * da * inv) / den);
    res.alpha = taob_pkg::ChW'(den / 255);
    return res;
  endfunction

  function automatic logic [taob_pkg::ChW-1:0] rand_chan();
    case ($urandom_range(7))
      0: return '0;
      1: return 8'd255;
      default: return taob_pkg::ChW'($urandom_range(255));
    endcase
  endfunction

  function automatic taob_pkg::pix_t rand_pixel();
    return px(rand_chan(), rand_chan(), rand_chan(), rand_chan());
  endfunction

  function automatic logic [taob_pkg::TintW-1:0] pick_tint();
    case ($urandom_range(5))
      0: return '0;
      1: return taob_pkg::TintReset;
      2: return 9'd511;
      default: return taob_pkg::TintW'($urandom_range(511));
    endcase
  endfunction

  // One beat on the pixel port; start stays high when the caller sends again.
  task automatic send_pixel(taob_pkg::pix_t src, taob_pkg::pix_t dst);
    start       <= 1'b1;
    src_red_i   <= src.red;
    src_green_i <= src.green;
    src_blue_i  <= src.blue;
    src_alpha_i <= src.alpha;
    dst_red_i   <= dst.red;
    dst_green_i <= dst.green;
    dst_blue_i  <= dst.blue;
    dst_alpha_i <= dst.alpha;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    exp_pixels = {exp_pixels, blend_over(src, dst)};
  endtask

  task automatic idle_for(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic wait_results_done();
    start <= 1'b0;
    while (exp_pixels.size() != 0) @(posedge clk_i);
    repeat (ResultLatency) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready. Upper data bits
  // may carry noise, since only the low nine bits belong to the register.
  task automatic write_tint(logic [taob_pkg::RegIdxW-1:0] idx,
                            logic [taob_pkg::TintW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= ((($urandom_range(1) != 0) ? taob_pkg::DataW'($urandom)
                                           : taob_pkg::DataW'(0))
                & ~taob_pkg::DataW'(9'h1FF)) | taob_pkg::DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tint_q[idx] = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_tints(logic [taob_pkg::TintW-1:0] r, logic [taob_pkg::TintW-1:0] g,
                           logic [taob_pkg::TintW-1:0] b, logic [taob_pkg::TintW-1:0] a);
    wait_results_done();
    write_tint(taob_pkg::RegTintRed, r);
    write_tint(taob_pkg::RegTintGreen, g);
    write_tint(taob_pkg::RegTintBlue, b);
    write_tint(taob_pkg::RegTintAlpha, a);
  endtask

  task automatic check_chan(string name, logic [taob_pkg::ChW-1:0] want,
                            logic [taob_pkg::ChW-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Results cannot be held off, so every strobe is one accepted beat.
  always @(posedge clk_i) begin
    taob_pkg::pix_t want;
    if (rst_ni && out_valid_o) begin
      if (exp_pixels.size() == 0) begin
        error_count++;
        $display("%0t: result beat with no pixel pending, actual %0d %0d %0d %0d",
                 $time, out_red_o, out_green_o, out_blue_o, out_alpha_o);
      end else begin
        want = exp_pixels.pop_front();
        check_chan("out_red", want.red, out_red_o);
        check_chan("out_green", want.green, out_green_o);
        check_chan("out_blue", want.blue, out_blue_o);
        check_chan("out_alpha", want.alpha, out_alpha_o);
      end
    end
  end

  initial begin
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || out_valid_o || (psel && penable && pwrite)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("[tinted_alpha_over_blend] ERROR");
    $finish;
  end

  task automatic test_default_tint_corners();
    send_pixel(px(0, 0, 0, 0), px(0, 0, 0, 0));
    send_pixel(px(255, 255, 255, 255), px(0, 0, 0, 0));
    send_pixel(px(10, 20, 30, 0), px(200, 100, 50, 255));
    send_pixel(px(255, 0, 128, 1), px(0, 255, 64, 255));
    send_pixel(px(12, 34, 56, 128), px(200, 150, 100, 0));
    send_pixel(px(0, 0, 0, 255), px(255, 255, 255, 255));
    send_pixel(px(255, 255, 255, 254), px(0, 0, 0, 255));
    send_pixel(px(77, 88, 99, 200), px(11, 22, 33, 100));
    send_pixel(px(255, 255, 255, 255), px(255, 255, 255, 255));
    send_pixel(px(1, 2, 3, 127), px(254, 253, 252, 1));
    wait_results_done();
  endtask

  task automatic test_tint_extremes();
    // A zero alpha tint makes every source transparent.
    set_tints('0, '0, '0, '0);
    send_pixel(px(255, 255, 255, 255), px(9, 8, 7, 6));
    send_pixel(px(100, 150, 200, 50), px(40, 30, 20, 10));
    // Tints above 1.0 can saturate the tinted channel.
    set_tints(9'd511, 9'd511, 9'd511, 9'd511);
    send_pixel(px(128, 255, 1, 128), px(10, 20, 30, 40));
    send_pixel(px(200, 129, 0, 255), px(255, 0, 255, 0));
    send_pixel(px(255, 255, 255, 1), px(0, 0, 0, 255));
    set_tints(9'd257, 9'd255, 9'd1, 9'd128);
    send_pixel(px(255, 255, 255, 1), px(5, 6, 7, 8));
    send_pixel(px(255, 255, 255, 255), px(100, 100, 100, 100));
    send_pixel(px(254, 2, 128, 3), px(255, 255, 255, 255));
    wait_results_done();
  endtask

  task automatic test_random_blends();
    int sent;
    int burst;
    for (int ph = 0; ph < RandomPhases; ph++) begin
      case (ph)
        0: set_tints(taob_pkg::TintReset, taob_pkg::TintReset,
                     taob_pkg::TintReset, taob_pkg::TintReset);
        1: set_tints(9'd511, 9'd511, 9'd511, 9'd511);
        2: set_tints('0, '0, '0, '0);
        default: set_tints(pick_tint(), pick_tint(), pick_tint(), pick_tint());
      endcase
      sent = 0;
      while (sent < PhasePixels) begin
        burst = $urandom_range(1, 24);
        for (int i = 0; i < burst && sent < PhasePixels; i++) begin
          send_pixel(rand_pixel(), rand_pixel());
          sent++;
        end
        if ($urandom_range(15) == 0) begin
          wait_results_done();
        end else if ($urandom_range(2) != 0) begin
          idle_for($urandom_range(1, 8));
        end
      end
      start <= 1'b0;
    end
    wait_results_done();
  endtask

  initial begin
    for (int i = 0; i < 4; i++) tint_q[i] = taob_pkg::TintReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_default_tint_corners();
    test_tint_extremes();
    test_random_blends();
    repeat (2 * ResultLatency) @(posedge clk_i);
    if (exp_pixels.size() != 0) begin
      error_count++;
      $display("%0t: %0d predicted pixels never arrived", $time, exp_pixels.size());
    end
    if (error_count == 0) begin
      $display("[tinted_alpha_over_blend] OK");
    end else begin
      $display("[tinted_alpha_over_blend] ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/taob_pkg.sv
rtl/taob_div.sv
rtl/tinted_alpha_over_blend.sv
verif/tb_tinted_alpha_over_blend.sv
